// ===== design/hvi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvi_pkg
// Types, codes, constants and saturation helpers of the Verlet integrator.
// ----------------------------------------------------------------------------
package hvi_pkg;

    localparam int DIMS_DEF = 16;

    localparam logic [31:0] STEP_SIZE_RST = 32'd65;
    localparam logic [31:0] ONE_Q16       = 32'h0001_0000;
    localparam logic [47:0] E48_MAX       = 48'hFFFF_FFFF_FFFF;
    localparam int          DIV_STEPS     = 48;

    // one memory entry: x, v, k, x0, m, f
    localparam int ENTRY_W = 32 + 32 + 31 + 32 + 31 + 32;

    localparam logic [1:0] REG_STEP_SIZE = 2'd0;

    typedef enum logic [1:0] {
        FN_LOAD = 2'd0,
        FN_RUN  = 2'd1,
        FN_READ = 2'd2,
        FN_ALT  = 2'd3
    } t_func;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_LATCH,
        S_FMUL, S_FRND, S_DIV, S_KMUL, S_KRND, S_DMUL, S_DRND,
        S_E1, S_E2, S_E3, S_E4, S_E5,
        S_WB, S_DONE
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/harmonic_verlet_integrator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// harmonic_verlet_integrator
// Velocity Verlet integration of independent harmonic axes in Q16.16.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries load, run and read items; the
// output channel (o_valid / i_stall) returns one result per item with the
// addressed dimension and the total potential and kinetic energies.
// Each item is one sweep over the state memory, one dimension at a time:
// read, integrate all step_count steps in registers for a run item, add the
// energies, write back. Since the axes are independent the steps of one
// dimension run back to back before the next dimension is read.
// Integration uses a restoring divider (a = f / m, twice a step) and the
// shared 32x32 multiplier; a massless dimension skips the divider.
// One item is in work at a time; o_stall is low only when idle. A finished
// result sits in the output register while the next item is taken; if it
// is still stalled when the next one finishes, that one waits.
// Reset: synchronous, active low; all entries read as their reset values
// (through per-entry valid bits) and step_size returns to 65.
// ----------------------------------------------------------------------------
module harmonic_verlet_integrator
    import hvi_pkg::*;
#(
    parameter int DIMS = DIMS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [1:0]          i_func,
    input  wire logic [3:0]          i_dim_index,
    input  wire logic signed [31:0]  i_position_in,
    input  wire logic signed [31:0]  i_velocity_in,
    input  wire logic [30:0]         i_stiffness_in,
    input  wire logic signed [31:0]  i_rest_position_in,
    input  wire logic [30:0]         i_mass_in,
    input  wire logic [15:0]         i_step_count,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic signed [31:0]       o_position_out,
    output logic signed [31:0]       o_velocity_out,
    output logic signed [31:0]       o_force_out,
    output logic [47:0]              o_potential_energy,
    output logic [47:0]              o_kinetic_energy,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [1:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int IW = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam logic [ENTRY_W-1:0] ENTRY_RST =
        {ONE_Q16, 32'd0, ONE_Q16[30:0], 32'd0, ONE_Q16[30:0], 32'd0};

    t_state r_state, n_state;

    // configuration
    logic [31:0] r_step_size;

    // item
    logic [1:0]         r_in_func;
    logic [3:0]         r_in_idx;
    logic signed [31:0] r_in_x, r_in_v, r_in_x0;
    logic [30:0]        r_in_k, r_in_m;
    logic [15:0]        r_in_n;

    // working dimension
    logic [IW-1:0]      r_dim;
    logic [DIMS-1:0]    r_vld;
    logic               r_rd_vld;
    logic signed [31:0] r_x, r_v, r_x0, r_f;
    logic [30:0]        r_k, r_m;
    logic [15:0]        r_steps;
    logic               r_phase, r_sgn, r_epass;
    logic [63:0]        r_prod, r_plo;
    logic [46:0]        r_sq;
    logic [31:0]        r_rem;
    logic [47:0]        r_quo;
    logic [5:0]         r_div_cnt;
    logic [47:0]        r_pe, r_ke;
    logic signed [31:0] r_cap_x, r_cap_v, r_cap_f;
    logic               r_ovalid;

    logic               in_take, out_take, idx_ok, hit, last_dim;
    logic [ENTRY_W-1:0] ram_q, entry, wdata;
    logic               ram_we;
    logic [31:0]        mul_a, mul_b;
    logic signed [31:0] disp, f_new, a_val, v_new, x_new, e_val;
    logic [31:0]        e_coef;
    logic [63:0]        rnd16, rnd17;
    logic [32:0]        rem_sh;
    logic [79:0]        p80;
    logic [47:0]        term, acc_old;
    logic [48:0]        acc_sum;
    logic [47:0]        acc_new;

    assign in_take  = i_valid && !o_stall;
    assign out_take = r_ovalid && !i_stall;
    assign idx_ok   = 32'(r_in_idx) < DIMS;
    assign hit      = idx_ok && (32'(r_dim) == 32'(r_in_idx));
    assign last_dim = 32'(r_dim) == DIMS - 1;

    hvi_ram #(.WIDTH(ENTRY_W), .DEPTH(DIMS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_dim),
        .i_wdata (wdata),
        .i_raddr (r_dim),
        .o_rdata (ram_q)
    );

    assign entry = r_rd_vld ? ram_q : ENTRY_RST;
    assign wdata = {r_x, r_v, r_k, r_x0, r_m, r_f};

    // datapath values
    assign disp  = sat32(64'(r_x) - 64'(r_x0));
    assign rnd16 = (r_prod + 64'd32768) >> 16;
    assign rnd17 = (r_prod + 64'd65536) >> 17;
    assign f_new = sat32(r_sgn ? $signed(rnd16) : -$signed(rnd16));
    assign a_val = sat32(r_f[31] ? -$signed({16'd0, r_quo}) : $signed({16'd0, r_quo}));
    assign v_new = sat32(64'(r_v) + (r_sgn ? -$signed(rnd17) : $signed(rnd17)));
    assign x_new = sat32(64'(r_x) + (r_sgn ? -$signed(rnd16) : $signed(rnd16)));
    assign rem_sh = {r_rem, r_quo[47]};

    assign e_val  = r_epass ? r_v : disp;
    assign e_coef = r_epass ? {1'b0, r_m} : {1'b0, r_k};
    assign p80    = 80'(r_plo) + (80'(r_prod) << 24) + 80'd65536;
    assign term   = (p80[79:64] != 16'd0) ? E48_MAX : {1'b0, p80[63:17]};
    assign acc_old = r_epass ? r_ke : r_pe;
    assign acc_sum = 49'(acc_old) + 49'(term);
    assign acc_new = acc_sum[48] ? E48_MAX : acc_sum[47:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_take) n_state = S_RD;
            S_RD:    n_state = S_LATCH;
            S_LATCH: n_state = (t_func'(r_in_func) == FN_RUN && r_in_n != 16'd0) ? S_FMUL : S_E1;
            S_FMUL:  n_state = S_FRND;
            S_FRND:  n_state = (r_m == 31'd0) ? S_KMUL : S_DIV;
            S_DIV:   if (r_div_cnt == 6'd1) n_state = S_KMUL;
            S_KMUL:  n_state = S_KRND;
            S_KRND: begin
                if (!r_phase) begin
                    n_state = S_DMUL;
                end else begin
                    n_state = (r_steps == 16'd1) ? S_E1 : S_FMUL;
                end
            end
            S_DMUL:  n_state = S_DRND;
            S_DRND:  n_state = S_FMUL;
            S_E1:    n_state = S_E2;
            S_E2:    n_state = S_E3;
            S_E3:    n_state = S_E4;
            S_E4:    n_state = S_E5;
            S_E5:    n_state = r_epass ? S_WB : S_E1;
            S_WB:    n_state = last_dim ? S_DONE : S_RD;
            S_DONE:  if (!r_ovalid || out_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs and multiplier operands
    always_comb begin
        o_stall = (r_state != S_IDLE);
        ram_we  = (r_state == S_WB);
        mul_a   = 32'd0;
        mul_b   = 32'd0;
        unique case (r_state)
            S_FMUL: begin
                mul_a = abs32(disp);
                mul_b = {1'b0, r_k};
            end
            S_KMUL: begin
                mul_a = abs32(a_val);
                mul_b = r_step_size;
            end
            S_DMUL: begin
                mul_a = abs32(r_v);
                mul_b = r_step_size;
            end
            S_E1: begin
                mul_a = abs32(e_val);
                mul_b = abs32(e_val);
            end
            S_E3: begin
                mul_a = e_coef;
                mul_b = {8'd0, r_sq[23:0]};
            end
            S_E4: begin
                mul_a = e_coef;
                mul_b = {9'd0, r_sq[46:24]};
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_STEP_SIZE) ? r_step_size : 32'd0;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step_size <= STEP_SIZE_RST;
            r_vld       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && pready && paddr == REG_STEP_SIZE) begin
                r_step_size <= pwdata;
            end
            if (r_state == S_WB) begin
                r_vld[r_dim] <= 1'b1;
            end
            if (r_state == S_DONE && (!r_ovalid || out_take)) begin
                r_ovalid <= 1'b1;
            end else if (out_take) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, mul_a} * {32'd0, mul_b};
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    r_in_func <= i_func;
                    r_in_idx  <= i_dim_index;
                    r_in_x    <= i_position_in;
                    r_in_v    <= i_velocity_in;
                    r_in_k    <= i_stiffness_in;
                    r_in_x0   <= i_rest_position_in;
                    r_in_m    <= i_mass_in;
                    r_in_n    <= i_step_count;
                    r_dim     <= '0;
                    r_pe      <= '0;
                    r_ke      <= '0;
                    r_cap_x   <= '0;
                    r_cap_v   <= '0;
                    r_cap_f   <= '0;
                end
            end
            S_RD: begin
                r_rd_vld <= r_vld[r_dim];
            end
            S_LATCH: begin
                if (t_func'(r_in_func) == FN_LOAD && hit) begin
                    r_x  <= r_in_x;
                    r_v  <= r_in_v;
                    r_k  <= r_in_k;
                    r_x0 <= r_in_x0;
                    r_m  <= r_in_m;
                    r_f  <= '0;
                end else begin
                    {r_x, r_v, r_k, r_x0, r_m, r_f} <= entry;
                end
                r_steps <= r_in_n;
                r_phase <= 1'b0;
                r_epass <= 1'b0;
            end
            S_FMUL: begin
                r_sgn <= disp[31];
            end
            S_FRND: begin
                // force, then start a = (f << 16) / m
                r_f       <= f_new;
                r_rem     <= '0;
                r_quo     <= (r_m == 31'd0) ? 48'd0 : {abs32(f_new), 16'd0};
                r_div_cnt <= 6'(DIV_STEPS);
            end
            S_DIV: begin
                if (rem_sh >= {2'd0, r_m}) begin
                    r_rem <= 32'(rem_sh - {2'd0, r_m});
                    r_quo <= {r_quo[46:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[31:0];
                    r_quo <= {r_quo[46:0], 1'b0};
                end
                r_div_cnt <= r_div_cnt - 6'd1;
            end
            S_KMUL: begin
                r_sgn <= a_val[31];
            end
            S_KRND: begin
                r_v <= v_new;
                if (r_phase) begin
                    r_steps <= r_steps - 16'd1;
                end
                r_phase <= !r_phase;
            end
            S_DMUL: begin
                r_sgn <= r_v[31];
            end
            S_DRND: begin
                r_x <= x_new;
            end
            S_E2: begin
                r_sq <= rnd16[46:0];
            end
            S_E4: begin
                r_plo <= r_prod;
            end
            S_E5: begin
                if (r_epass) begin
                    r_ke <= acc_new;
                end else begin
                    r_pe <= acc_new;
                end
                r_epass <= 1'b1;
            end
            S_WB: begin
                if (hit) begin
                    r_cap_x <= r_x;
                    r_cap_v <= r_v;
                    r_cap_f <= r_f;
                end
                if (!last_dim) begin
                    r_dim <= r_dim + IW'(1);
                end
            end
            S_DONE: begin
                if (!r_ovalid || out_take) begin
                    o_position_out     <= r_cap_x;
                    o_velocity_out     <= r_cap_v;
                    o_force_out        <= r_cap_f;
                    o_potential_energy <= r_pe;
                    o_kinetic_energy   <= r_ke;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_ovalid;

`ifndef SYNTH
    a_take_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_state == S_RD)
        else $error("accepted item did not start a sweep");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result raised outside completion");

    a_div_nonzero_mass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_m != 31'd0 && r_div_cnt != 6'd0)
        else $error("divider running with zero mass or spent count");
`endif

endmodule
`default_nettype wire

// ===== design/hvi_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvi_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hvi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the harmonic Verlet integrator. Load, run and read
// transfers are offered with random gaps against a randomly stalling receiver;
// a fixed-point model of the oscillator predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
    import hvi_pkg::*;

    localparam int  NDIM      = 16;
    localparam int  LIMIT     = 6_000_000;
    localparam int  LONG_HOLD = 4000;
    localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        t_func              fn;
        logic [3:0]         dim;
        logic signed [31:0] xp;
        logic signed [31:0] vp;
        logic [30:0]        kp;
        logic signed [31:0] x0p;
        logic [30:0]        mp;
        logic [15:0]        nsteps;
    } t_item;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] v;
        logic signed [31:0] f;
        logic [47:0]        pe;
        logic [47:0]        ke;
    } t_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_func;
    logic [3:0]         i_dim_index;
    logic signed [31:0] i_position_in;
    logic signed [31:0] i_velocity_in;
    logic [30:0]        i_stiffness_in;
    logic signed [31:0] i_rest_position_in;
    logic [30:0]        i_mass_in;
    logic [15:0]        i_step_count;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_position_out;
    logic signed [31:0] o_velocity_out;
    logic signed [31:0] o_force_out;
    logic [47:0]        o_potential_energy;
    logic [47:0]        o_kinetic_energy;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [1:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    harmonic_verlet_integrator i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_func             (i_func),
        .i_dim_index        (i_dim_index),
        .i_position_in      (i_position_in),
        .i_velocity_in      (i_velocity_in),
        .i_stiffness_in     (i_stiffness_in),
        .i_rest_position_in (i_rest_position_in),
        .i_mass_in          (i_mass_in),
        .i_step_count       (i_step_count),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_position_out     (o_position_out),
        .o_velocity_out     (o_velocity_out),
        .o_force_out        (o_force_out),
        .o_potential_energy (o_potential_energy),
        .o_kinetic_energy   (o_kinetic_energy),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // oscillator state as seen by the predictor
    longint          osc_x[NDIM];
    longint          osc_v[NDIM];
    longint unsigned osc_k[NDIM];
    longint          osc_x0[NDIM];
    longint unsigned osc_m[NDIM];
    longint          osc_f[NDIM];
    longint unsigned osc_dt;

    t_item   stim_items[$];
    t_result pending_results[$];
    t_item   cur_item;

    int  errors = 0;
    int  cycles = 0;
    int  gap_left = 0;
    int  rx_gap = 0;
    int  hold_left = 0;
    bit  hold_kick = 0;
    int  n_load = 0, n_run = 0, n_read = 0, n_steps = 0, n_results = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // round(a*b / 2^s), ties away from zero
    function automatic longint round_mul(longint a, longint unsigned b, int s);
        longint unsigned mag;
        longint unsigned r;
        mag = (a < 0) ? longint'(-a) : longint'(a);
        r = (mag * b + (64'd1 << (s - 1))) >> s;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint displacement(int i);
        return clamp32(osc_x[i] - osc_x0[i]);
    endfunction

    function automatic void spring_forces();
        for (int i = 0; i < NDIM; i++)
            osc_f[i] = clamp32(-round_mul(displacement(i), osc_k[i], 16));
    endfunction

    function automatic longint accel(int i);
        if (osc_m[i] == 0) return 0;
        return clamp32((osc_f[i] * 65536) / longint'(osc_m[i]));
    endfunction

    function automatic void half_kick();
        for (int i = 0; i < NDIM; i++)
            osc_v[i] = clamp32(osc_v[i] + round_mul(accel(i), osc_dt, 17));
    endfunction

    function automatic longint unsigned energy_term(longint val, longint unsigned coef);
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned t;
        mag = (val < 0) ? longint'(-val) : longint'(val);
        sq = (mag * mag + 32768) >> 16;
        if (sq != 0 && coef > (U64_MAX - 65536) / sq) return E48_MAX;
        t = (coef * sq + 65536) >> 17;
        return (t > E48_MAX) ? E48_MAX : t;
    endfunction

    function automatic void reset_oscillator();
        osc_dt = STEP_SIZE_RST;
        for (int i = 0; i < NDIM; i++) begin
            osc_x[i]  = 65536;
            osc_v[i]  = 0;
            osc_k[i]  = 65536;
            osc_x0[i] = 0;
            osc_m[i]  = 65536;
            osc_f[i]  = 0;
        end
    endfunction

    function automatic t_result advance_oscillator(t_item it);
        t_result         r;
        longint unsigned pe;
        longint unsigned ke;
        int              d;
        d = it.dim;
        pe = 0;
        ke = 0;
        case (it.fn)
            FN_LOAD: begin
                osc_x[d]  = it.xp;
                osc_v[d]  = it.vp;
                osc_k[d]  = it.kp;
                osc_x0[d] = it.x0p;
                osc_m[d]  = it.mp;
                osc_f[d]  = 0;
            end
            FN_RUN: begin
                for (int s = 0; s < it.nsteps; s++) begin
                    spring_forces();
                    half_kick();
                    for (int i = 0; i < NDIM; i++)
                        osc_x[i] = clamp32(osc_x[i] + round_mul(osc_v[i], osc_dt, 16));
                    spring_forces();
                    half_kick();
                end
            end
            default: ;
        endcase
        for (int i = 0; i < NDIM; i++) begin
            pe = pe + energy_term(displacement(i), osc_k[i]);
            if (pe > E48_MAX) pe = E48_MAX;
            ke = ke + energy_term(osc_v[i], osc_m[i]);
            if (ke > E48_MAX) ke = E48_MAX;
        end
        r.x  = osc_x[d][31:0];
        r.v  = osc_v[d][31:0];
        r.f  = osc_f[d][31:0];
        r.pe = pe[47:0];
        r.ke = ke[47:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
            4, 5:       return $urandom;
            6:          return 32'h7FFF_FFFF;
            7:          return 32'h8000_0000;
            default:    return 32'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    function automatic logic [30:0] pick_coef();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 31'($urandom_range(4096, 4 * 65536));
            5:             return 31'($urandom);
            6:             return 31'h7FFF_FFFF;
            7:             return 31'd0;
            8:             return 31'd1;
            default:       return 31'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    sel;
        sel = $urandom_range(0, 99);
        it.fn = (sel < 35) ? FN_LOAD : (sel < 60) ? FN_RUN : (sel < 95) ? FN_READ : FN_ALT;
        it.dim = 4'($urandom);
        it.xp = pick_q16();
        it.vp = pick_q16();
        it.kp = pick_coef();
        it.x0p = pick_q16();
        it.mp = pick_coef();
        if (it.fn == FN_RUN) begin
            sel = $urandom_range(0, 99);
            // keep runs short: each step sweeps every dimension
            it.nsteps = (sel < 15) ? 16'd0 : (sel < 90) ? 16'd1 : 16'($urandom_range(2, 3));
        end else begin
            it.nsteps = 16'($urandom);
        end
        return it;
    endfunction

    function automatic t_item make_item(t_func fn, int dim, logic [31:0] x, logic [31:0] v,
                                        logic [30:0] k, logic [31:0] x0, logic [30:0] m,
                                        int n);
        t_item it;
        it.fn = fn;
        it.dim = 4'(dim);
        it.xp = x;
        it.vp = v;
        it.kp = k;
        it.x0p = x0;
        it.mp = m;
        it.nsteps = 16'(n);
        return it;
    endfunction

    // sample on the falling edge, once the driver and monitor have settled
    task automatic drain();
        while (stim_items.size() != 0 || i_valid || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_step_size(logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_STEP_SIZE;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        osc_dt = value;
    endtask

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("mismatch on result %0d: %s got %h expected %h", n_results, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // clock, timeout
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // driver: offer queued items, predict on each accepted transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                pending_results.push_back(advance_oscillator(cur_item));
                case (cur_item.fn)
                    FN_LOAD: n_load++;
                    FN_RUN: begin
                        n_run++;
                        n_steps += cur_item.nsteps;
                    end
                    default: n_read++;
                endcase
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0 || stim_items.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_valid <= 1'b0;
                end else begin
                    cur_item = stim_items.pop_front();
                    i_valid            <= 1'b1;
                    i_func             <= cur_item.fn;
                    i_dim_index        <= cur_item.dim;
                    i_position_in      <= cur_item.xp;
                    i_velocity_in      <= cur_item.vp;
                    i_stiffness_in     <= cur_item.kp;
                    i_rest_position_in <= cur_item.x0p;
                    i_mass_in          <= cur_item.mp;
                    i_step_count       <= cur_item.nsteps;
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7: gap_left = 0;
                        18, 19:                 gap_left = $urandom_range(20, 80);
                        default:                gap_left = $urandom_range(1, 4);
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stall: random gaps, plus one long hold on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_kick) begin
            hold_kick = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_stall <= 1'b1;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2:  rx_gap = $urandom_range(1, 4);
                3:        rx_gap = $urandom_range(20, 100);
                default:  rx_gap = 0;
            endcase
            i_stall <= (rx_gap > 0);
        end
    end

    // ------------------------------------------------------------------
    // monitor: compare each result transfer with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("unexpected result transfer %0d", n_results);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_position_out !== want.x) flag_mismatch("position", o_position_out, want.x);
                if (o_velocity_out !== want.v) flag_mismatch("velocity", o_velocity_out, want.v);
                if (o_force_out !== want.f) flag_mismatch("force", o_force_out, want.f);
                if (o_potential_energy !== want.pe)
                    flag_mismatch("potential", o_potential_energy, want.pe);
                if (o_kinetic_energy !== want.ke)
                    flag_mismatch("kinetic", o_kinetic_energy, want.ke);
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] dt_vals[5];
        int          counts[5];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_func = FN_READ;
        i_dim_index = '0;
        i_position_in = '0;
        i_velocity_in = '0;
        i_stiffness_in = '0;
        i_rest_position_in = '0;
        i_mass_in = '0;
        i_step_count = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        reset_oscillator();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset state, field extremes, zero mass, code 3, zero steps
        stim_items.push_back(make_item(FN_READ, 0, 0, 0, 0, 0, 0, 0));
        stim_items.push_back(make_item(FN_RUN, 5, 0, 0, 0, 0, 0, 1));
        stim_items.push_back(make_item(FN_LOAD, 0, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                                       32'h8000_0000, 31'h7FFF_FFFF, 16'hFFFF));
        stim_items.push_back(make_item(FN_LOAD, 1, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0,
                                       32'h7FFF_FFFF, 31'd0, 0));
        stim_items.push_back(make_item(FN_LOAD, 2, 32'h0002_0000, 32'hFFFF_0000, 31'd1,
                                       32'hFFFF_8000, 31'd1, 0));
        stim_items.push_back(make_item(FN_LOAD, 15, 32'h0000_8000, 32'h0001_0000, 31'h0004_0000,
                                       0, 31'h0000_4000, 16'h5555));
        stim_items.push_back(make_item(FN_READ, 0, 0, 0, 0, 0, 0, 16'hAAAA));
        stim_items.push_back(make_item(FN_ALT, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                                       32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF));
        stim_items.push_back(make_item(FN_RUN, 0, 0, 0, 0, 0, 0, 0));
        stim_items.push_back(make_item(FN_RUN, 2, 0, 0, 0, 0, 0, 1));
        stim_items.push_back(make_item(FN_READ, 1, 0, 0, 0, 0, 0, 0));
        stim_items.push_back(make_item(FN_READ, 15, 0, 0, 0, 0, 0, 0));
        stim_items.push_back(make_item(FN_RUN, 15, 0, 0, 0, 0, 0, 5));
        stim_items.push_back(make_item(FN_READ, 2, 0, 0, 0, 0, 0, 0));
        stim_items.push_back(make_item(FN_ALT, 15, 0, 0, 0, 0, 0, 0));
        drain();

        // sweep the time step, extremes included; hold the receiver once
        dt_vals = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'd1, 32'd65};
        counts  = '{60, 40, 120, 80, 200};
        for (int p = 0; p < 5; p++) begin
            write_step_size(dt_vals[p]);
            if (p == 3) hold_kick = 1'b1;
            for (int j = 0; j < counts[p]; j++)
                stim_items.push_back(random_item());
            drain();
        end

        $display("covered %0d loads, %0d runs (%0d steps), %0d reads/alt reads, %0d results",
                 n_load, n_run, n_steps, n_read, n_results);
        $display("time step swept over zero, one, reset value, random and all-ones");
        if (pending_results.size() != 0) begin
            $display("%0d predicted results never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
